[rtl/boundary_tag_first_fit_allocator_defines.svh]
// assertion macros for the boundary tag allocator
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define BTFFA_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication
`define BTFFA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`else

`define BTFFA_ASSERT_SAME(name, ante, cons)
`define BTFFA_ASSERT_NEXT(name, ante, cons)

`endif

`endif

[rtl/btffa_pkg.sv]
package btffa_pkg;

    // width of internal address and size arithmetic, wide enough to keep sign
    localparam int VW = 38;

    typedef logic [VW-1:0] val_t;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_NULL  = 2'd1;
    localparam logic [1:0] STATUS_LIMIT = 2'd2;

    // heap layout after reset
    localparam int         INIT_BREAK    = 4112;
    localparam int         INIT_CHUNK    = 4096;
    localparam int         MIN_BLOCK     = 16;
    localparam logic [31:0] PROLOGUE_TAG = 32'd9;
    localparam logic [31:0] EPILOGUE_TAG = 32'd1;
    localparam int         PRO_HDR_WORD  = 1;
    localparam int         PRO_FTR_WORD  = 2;
    localparam int         FREE_HDR_WORD = 3;
    localparam int         FREE_FTR_WORD = 1026;
    localparam int         EPI_WORD      = 1027;

endpackage

[rtl/boundary_tag_first_fit_allocator.sv]
// Boundary tag heap allocator with first-fit search over the implicit block list.
// Command channel: op, request_bytes and block_addr are taken at a clock edge with
// start high and busy low. busy stays high until the command has finished.
// Result channel: done is high for exactly one cycle with result_addr and status;
// the receiver cannot stall it, and a new command may be started in that cycle.
// Config: extend_chunk_bytes is written when extend_chunk_bytes_we is high.
// Operation: a null request or null free answers straight from idle. A free rewrites
// both tags, then merges with its neighbors. An allocate walks the block headers in
// the first-fit search (one memory read per header), then places the block; growing
// the heap adds a merge. All tag accesses go through one memory port pair and one
// shared adder.
// Reset: after rst_n is released the heap memory is rewritten one word per cycle,
// laying out prologue, epilogue and the first free chunk; busy is high during
// this pass.
module boundary_tag_first_fit_allocator import btffa_pkg::*; #(
    parameter int HEAP_BYTES = 1048576
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [20:0] request_bytes,
    input  logic [20:0] block_addr,
    input  logic        extend_chunk_bytes_we,
    input  logic [16:0] extend_chunk_bytes,
    output logic        done,
    output logic [20:0] result_addr,
    output logic [1:0]  status
);

    `include "boundary_tag_first_fit_allocator_defines.svh"

    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int IW         = $clog2(HEAP_WORDS);
    localparam int BW         = $clog2(HEAP_BYTES + 1);

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE,
        S_SRCH_RD, S_SRCH_EV,
        S_GROW_CHK, S_GROW_W1, S_GROW_W2, S_GROW_W3,
        S_M_RDH, S_M_RDF, S_M_PREV, S_M_NEXT, S_M_RDN, S_M_DEC,
        S_M_A_W1, S_M_A_T, S_M_A_W2,
        S_M_RDP, S_M_SUMP, S_M_B_W1, S_M_B_W2,
        S_M_C_ADR, S_M_C_RDN, S_M_C_SUMN, S_M_C_W1, S_M_C_T, S_M_C_W2,
        S_M_RET,
        S_P_RD, S_P_CAP, S_P_S_W1, S_P_S_T, S_P_S_W2, S_P_S_REM, S_P_S_W3,
        S_P_S_T2, S_P_S_W4, S_P_N_W1, S_P_N_T, S_P_N_W2,
        S_F_RD, S_F_CAP, S_F_T, S_F_W2
    } state_t;

    state_t        state_reg, state_next;
    val_t          p_reg, p_next;
    val_t          sz_reg, sz_next;
    val_t          prev_reg, prev_next;
    val_t          nxt_reg, nxt_next;
    val_t          nsz_reg, nsz_next;
    val_t          t_reg, t_next;
    val_t          have_reg, have_next;
    logic [21:0]   need_reg, need_next;
    logic          pa_reg, pa_next;
    logic          na_reg, na_next;
    logic          grow_reg, grow_next;
    logic          oob_reg, oob_next;
    logic [BW-1:0] brk_reg, brk_next;
    logic [16:0]   chunk_reg, chunk_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic          done_reg, done_next;
    logic [20:0]   res_reg, res_next;
    logic [1:0]    status_reg, status_next;

    // shared adder and memory hookup
    val_t          alu_a, alu_b, alu_sum;
    logic          alu_sub, alu_oob;
    logic [IW-1:0] alu_idx;
    logic          mem_we, mem_wr;
    logic [IW-1:0] mem_waddr;
    logic [31:0]   mem_wdata, mem_wd, mem_rdata;
    logic [31:0]   rval;
    val_t          tsz;
    logic [21:0]   req_up, need_calc, ext;
    logic [20:0]   ext_words;
    logic [22:0]   gsz;
    logic [31:0]   init_word;

    btffa_alu #(.HEAP_BYTES(HEAP_BYTES)) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum),
        .oob (alu_oob),
        .idx (alu_idx)
    );

    btffa_ram #(.WIDTH(32), .DEPTH(HEAP_WORDS)) u_heap (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (alu_idx),
        .rdata (mem_rdata)
    );

    // tag read back; out-of-range reads look like an epilogue tag
    assign rval = oob_reg ? EPILOGUE_TAG : mem_rdata;
    assign tsz  = val_t'({rval[31:3], 3'b000});

    // block size for a request
    assign req_up    = 22'(request_bytes) + 22'd15;
    assign need_calc = (request_bytes <= 21'd8) ? 22'(MIN_BLOCK) : {req_up[21:3], 3'b000};

    // growth size: larger of need and chunk, whole words, even word count
    assign ext       = (need_reg > 22'(chunk_reg)) ? need_reg : 22'(chunk_reg);
    assign ext_words = 21'(ext[21:2]) + 21'(ext[2]);
    assign gsz       = {ext_words, 2'b00};

    // initial heap image used by the clearing pass
    always_comb
    begin
        if (clr_reg == IW'(PRO_HDR_WORD) || clr_reg == IW'(PRO_FTR_WORD))
        begin
            init_word = PROLOGUE_TAG;
        end
        else if (clr_reg == IW'(FREE_HDR_WORD) || clr_reg == IW'(FREE_FTR_WORD))
        begin
            init_word = 32'(INIT_CHUNK);
        end
        else if (clr_reg == IW'(EPI_WORD))
        begin
            init_word = EPILOGUE_TAG;
        end
        else
        begin
            init_word = 32'd0;
        end
    end

    // write port: clearing pass or a tag write that lands inside the heap
    assign mem_we    = (state_reg == S_CLEAR) ? 1'b1 : (mem_wr && !alu_oob);
    assign mem_waddr = (state_reg == S_CLEAR) ? clr_reg : alu_idx;
    assign mem_wdata = (state_reg == S_CLEAR) ? init_word : mem_wd;

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        p_next      = p_reg;
        sz_next     = sz_reg;
        prev_next   = prev_reg;
        nxt_next    = nxt_reg;
        nsz_next    = nsz_reg;
        t_next      = t_reg;
        have_next   = have_reg;
        need_next   = need_reg;
        pa_next     = pa_reg;
        na_next     = na_reg;
        grow_next   = grow_reg;
        oob_next    = oob_reg;
        brk_next    = brk_reg;
        chunk_next  = extend_chunk_bytes_we ? extend_chunk_bytes : chunk_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        status_next = status_reg;
        alu_a       = p_reg;
        alu_b       = val_t'(4);
        alu_sub     = 1'b1;
        mem_wr      = 1'b0;
        mem_wd      = sz_reg[31:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'(HEAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_ALLOC)
                    begin
                        need_next = need_calc;
                        p_next    = val_t'(8);
                        if (request_bytes == 21'd0)
                        begin
                            done_next   = 1'b1;
                            res_next    = 21'd0;
                            status_next = STATUS_NULL;
                        end
                        else
                        begin
                            state_next = S_SRCH_RD;
                        end
                    end
                    else
                    begin
                        p_next    = val_t'(block_addr);
                        grow_next = 1'b0;
                        if (block_addr == 21'd0)
                        begin
                            done_next   = 1'b1;
                            res_next    = 21'd0;
                            status_next = STATUS_NULL;
                        end
                        else
                        begin
                            state_next = S_F_RD;
                        end
                    end
                end
            end
            // first-fit walk, one header read per block
            S_SRCH_RD:
            begin
                oob_next = alu_oob;
                if (p_reg >= val_t'(HEAP_BYTES))
                begin
                    state_next = S_GROW_CHK;
                end
                else
                begin
                    state_next = S_SRCH_EV;
                end
            end
            S_SRCH_EV:
            begin
                alu_b   = tsz;
                alu_sub = 1'b0;
                if (tsz == '0)
                begin
                    state_next = S_GROW_CHK;
                end
                else if (!rval[0] && val_t'(need_reg) <= tsz)
                begin
                    state_next = S_P_RD;
                end
                else
                begin
                    p_next     = alu_sum;
                    state_next = S_SRCH_RD;
                end
            end
            // heap growth at the break
            S_GROW_CHK:
            begin
                alu_a   = val_t'(brk_reg);
                alu_b   = val_t'(gsz);
                alu_sub = 1'b0;
                if (alu_sum > val_t'(HEAP_BYTES))
                begin
                    done_next   = 1'b1;
                    res_next    = 21'd0;
                    status_next = STATUS_LIMIT;
                    state_next  = S_IDLE;
                end
                else
                begin
                    sz_next    = val_t'(gsz);
                    t_next     = alu_sum;
                    p_next     = val_t'(brk_reg);
                    state_next = S_GROW_W1;
                end
            end
            S_GROW_W1:
            begin
                mem_wr     = 1'b1;
                state_next = S_GROW_W2;
            end
            S_GROW_W2:
            begin
                alu_a      = t_reg;
                alu_b      = val_t'(8);
                mem_wr     = 1'b1;
                state_next = S_GROW_W3;
            end
            S_GROW_W3:
            begin
                alu_a      = t_reg;
                mem_wr     = 1'b1;
                mem_wd     = EPILOGUE_TAG;
                brk_next   = t_reg[BW-1:0];
                grow_next  = 1'b1;
                state_next = S_M_RDH;
            end
            // merge: read own header, previous footer, next header
            S_M_RDH:
            begin
                oob_next   = alu_oob;
                state_next = S_M_RDF;
            end
            S_M_RDF:
            begin
                sz_next    = tsz;
                alu_b      = val_t'(8);
                oob_next   = alu_oob;
                state_next = S_M_PREV;
            end
            S_M_PREV:
            begin
                alu_b      = tsz;
                pa_next    = rval[0];
                prev_next  = alu_sum;
                state_next = S_M_NEXT;
            end
            S_M_NEXT:
            begin
                alu_b      = sz_reg;
                alu_sub    = 1'b0;
                nxt_next   = alu_sum;
                state_next = S_M_RDN;
            end
            S_M_RDN:
            begin
                alu_a      = nxt_reg;
                oob_next   = alu_oob;
                state_next = S_M_DEC;
            end
            S_M_DEC:
            begin
                alu_a    = sz_reg;
                alu_b    = tsz;
                alu_sub  = 1'b0;
                nsz_next = tsz;
                na_next  = rval[0];
                if (pa_reg && rval[0])
                begin
                    state_next = S_M_RET;
                end
                else if (pa_reg)
                begin
                    sz_next    = alu_sum;
                    state_next = S_M_A_W1;
                end
                else
                begin
                    state_next = S_M_RDP;
                end
            end
            // merge with the next block only
            S_M_A_W1:
            begin
                mem_wr     = 1'b1;
                state_next = S_M_A_T;
            end
            S_M_A_T:
            begin
                alu_b      = sz_reg;
                alu_sub    = 1'b0;
                t_next     = alu_sum;
                state_next = S_M_A_W2;
            end
            S_M_A_W2:
            begin
                alu_a      = t_reg;
                alu_b      = val_t'(8);
                mem_wr     = 1'b1;
                state_next = S_M_RET;
            end
            // previous block is free
            S_M_RDP:
            begin
                alu_a      = prev_reg;
                oob_next   = alu_oob;
                state_next = S_M_SUMP;
            end
            S_M_SUMP:
            begin
                alu_a   = sz_reg;
                alu_b   = tsz;
                alu_sub = 1'b0;
                sz_next = alu_sum;
                if (na_reg)
                begin
                    state_next = S_M_B_W1;
                end
                else
                begin
                    state_next = S_M_C_ADR;
                end
            end
            S_M_B_W1:
            begin
                alu_a      = nxt_reg;
                alu_b      = val_t'(8);
                mem_wr     = 1'b1;
                state_next = S_M_B_W2;
            end
            S_M_B_W2:
            begin
                alu_a      = prev_reg;
                mem_wr     = 1'b1;
                p_next     = prev_reg;
                state_next = S_M_RET;
            end
            // both neighbors free
            S_M_C_ADR:
            begin
                alu_a      = nxt_reg;
                alu_b      = nsz_reg;
                alu_sub    = 1'b0;
                t_next     = alu_sum;
                state_next = S_M_C_RDN;
            end
            S_M_C_RDN:
            begin
                alu_a      = t_reg;
                alu_b      = val_t'(8);
                oob_next   = alu_oob;
                state_next = S_M_C_SUMN;
            end
            S_M_C_SUMN:
            begin
                alu_a      = sz_reg;
                alu_b      = tsz;
                alu_sub    = 1'b0;
                sz_next    = alu_sum;
                state_next = S_M_C_W1;
            end
            S_M_C_W1:
            begin
                alu_a      = prev_reg;
                mem_wr     = 1'b1;
                state_next = S_M_C_T;
            end
            S_M_C_T:
            begin
                alu_a      = prev_reg;
                alu_b      = sz_reg;
                alu_sub    = 1'b0;
                t_next     = alu_sum;
                state_next = S_M_C_W2;
            end
            S_M_C_W2:
            begin
                alu_a      = t_reg;
                alu_b      = val_t'(8);
                mem_wr     = 1'b1;
                p_next     = prev_reg;
                state_next = S_M_RET;
            end
            S_M_RET:
            begin
                if (grow_reg)
                begin
                    state_next = S_P_RD;
                end
                else
                begin
                    done_next   = 1'b1;
                    res_next    = 21'd0;
                    status_next = STATUS_DONE;
                    state_next  = S_IDLE;
                end
            end
            // place: mark allocated, split off a free remainder when large enough
            S_P_RD:
            begin
                oob_next   = alu_oob;
                state_next = S_P_CAP;
            end
            S_P_CAP:
            begin
                have_next = tsz;
                if (tsz >= val_t'(need_reg) + val_t'(MIN_BLOCK))
                begin
                    state_next = S_P_S_W1;
                end
                else
                begin
                    state_next = S_P_N_W1;
                end
            end
            S_P_S_W1:
            begin
                mem_wr     = 1'b1;
                mem_wd     = 32'(need_reg) | 32'd1;
                state_next = S_P_S_T;
            end
            S_P_S_T:
            begin
                alu_b      = val_t'(need_reg);
                alu_sub    = 1'b0;
                t_next     = alu_sum;
                state_next = S_P_S_W2;
            end
            S_P_S_W2:
            begin
                alu_a      = t_reg;
                alu_b      = val_t'(8);
                mem_wr     = 1'b1;
                mem_wd     = 32'(need_reg) | 32'd1;
                state_next = S_P_S_REM;
            end
            S_P_S_REM:
            begin
                alu_a      = have_reg;
                alu_b      = val_t'(need_reg);
                sz_next    = alu_sum;
                state_next = S_P_S_W3;
            end
            S_P_S_W3:
            begin
                alu_a      = t_reg;
                mem_wr     = 1'b1;
                state_next = S_P_S_T2;
            end
            S_P_S_T2:
            begin
                alu_a      = t_reg;
                alu_b      = sz_reg;
                alu_sub    = 1'b0;
                t_next     = alu_sum;
                state_next = S_P_S_W4;
            end
            S_P_S_W4:
            begin
                alu_a       = t_reg;
                alu_b       = val_t'(8);
                mem_wr      = 1'b1;
                done_next   = 1'b1;
                res_next    = p_reg[20:0];
                status_next = STATUS_DONE;
                state_next  = S_IDLE;
            end
            S_P_N_W1:
            begin
                mem_wr     = 1'b1;
                mem_wd     = have_reg[31:0] | 32'd1;
                state_next = S_P_N_T;
            end
            S_P_N_T:
            begin
                alu_b      = have_reg;
                alu_sub    = 1'b0;
                t_next     = alu_sum;
                state_next = S_P_N_W2;
            end
            S_P_N_W2:
            begin
                alu_a       = t_reg;
                alu_b       = val_t'(8);
                mem_wr      = 1'b1;
                mem_wd      = have_reg[31:0] | 32'd1;
                done_next   = 1'b1;
                res_next    = p_reg[20:0];
                status_next = STATUS_DONE;
                state_next  = S_IDLE;
            end
            // free: rewrite both tags without the allocated bit, then merge
            S_F_RD:
            begin
                oob_next   = alu_oob;
                state_next = S_F_CAP;
            end
            S_F_CAP:
            begin
                sz_next    = tsz;
                mem_wr     = 1'b1;
                mem_wd     = tsz[31:0];
                state_next = S_F_T;
            end
            S_F_T:
            begin
                alu_b      = sz_reg;
                alu_sub    = 1'b0;
                t_next     = alu_sum;
                state_next = S_F_W2;
            end
            S_F_W2:
            begin
                alu_a      = t_reg;
                alu_b      = val_t'(8);
                mem_wr     = 1'b1;
                state_next = S_M_RDH;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            p_reg      <= '0;
            sz_reg     <= '0;
            prev_reg   <= '0;
            nxt_reg    <= '0;
            nsz_reg    <= '0;
            t_reg      <= '0;
            have_reg   <= '0;
            need_reg   <= '0;
            pa_reg     <= 1'b0;
            na_reg     <= 1'b0;
            grow_reg   <= 1'b0;
            oob_reg    <= 1'b0;
            brk_reg    <= BW'(INIT_BREAK);
            chunk_reg  <= 17'(INIT_CHUNK);
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            res_reg    <= '0;
            status_reg <= STATUS_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            p_reg      <= p_next;
            sz_reg     <= sz_next;
            prev_reg   <= prev_next;
            nxt_reg    <= nxt_next;
            nsz_reg    <= nsz_next;
            t_reg      <= t_next;
            have_reg   <= have_next;
            need_reg   <= need_next;
            pa_reg     <= pa_next;
            na_reg     <= na_next;
            grow_reg   <= grow_next;
            oob_reg    <= oob_next;
            brk_reg    <= brk_next;
            chunk_reg  <= chunk_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
            res_reg    <= res_next;
            status_reg <= status_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign result_addr = res_reg;
    assign status      = status_reg;

    // checks
    `BTFFA_ASSERT_SAME(a_done_idle, done, !busy)
    `BTFFA_ASSERT_NEXT(a_start_progress, start && !busy, busy || done)
    `BTFFA_ASSERT_SAME(a_fail_null_addr, done && status != STATUS_DONE, result_addr == 21'd0)

endmodule

[rtl/btffa_ram.sv]
module btffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 262144,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/btffa_alu.sv]
module btffa_alu import btffa_pkg::*; #(
    parameter int HEAP_BYTES = 1048576,
    localparam int IW        = $clog2(HEAP_BYTES / 4)
) (
    input  val_t          a,
    input  val_t          b,
    input  logic          sub,
    output val_t          sum,
    output logic          oob,
    output logic [IW-1:0] idx
);

    // shared add/subtract with heap range check on the result
    always_comb
    begin
        sum = a + (sub ? ~b : b) + val_t'(sub);
        oob = sum[VW-1] || (sum >= val_t'(HEAP_BYTES));
        idx = sum[2 +: IW];
    end

endmodule
